### sv/mpsc_pkg.sv
// Shared widths and types for the motor position/speed controller.
`default_nettype none
package mpsc_pkg;
  localparam int SIG_W         = 32;
  localparam int MUL_W         = 33;
  localparam int PROD_W        = 66;
  localparam int DV_IN_W       = 36;
  localparam int TAP_COUNT_DEF = 4;
  localparam int VOLT_LIM_DEF  = 12;
  typedef logic signed [SIG_W-1:0]  sig_t;
  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;
endpackage
`default_nettype wire

### sv/mpsc_if.sv
// Input and result channel interfaces.
`default_nettype none
interface mpsc_in_if;
  import mpsc_pkg::*;
  logic valid;
  logic ready;
  sig_t reference;
  sig_t encoder_count;
  logic restart;
  modport source(output valid, reference, encoder_count, restart, input ready);
  modport sink(input valid, reference, encoder_count, restart, output ready);
endinterface

interface mpsc_out_if;
  import mpsc_pkg::*;
  logic valid;
  logic ready;
  sig_t voltage;
  logic saturated;
  modport source(output valid, voltage, saturated, input ready);
  modport sink(input valid, voltage, saturated, output ready);
endinterface
`default_nettype wire

### sv/mpsc_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module mpsc_mul (
  input  logic                clk,
  input  mpsc_pkg::mop_t      a,
  input  mpsc_pkg::mop_t      b,
  output mpsc_pkg::prod_t     p
);
  import mpsc_pkg::*;
  prod_t p_r;
  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end
  assign p = p_r;
endmodule
`default_nettype wire

### sv/mpsc_div5.sv
// Floor divide by five for the speed low-pass: shift-add estimate, then correction.
`default_nettype none
module mpsc_div5 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mpsc_pkg::DV_IN_W-1:0] t,
  output logic                                busy,
  output mpsc_pkg::sig_t                      q
);
  import mpsc_pkg::*;
  localparam int            XW   = DV_IN_W + 4;
  // offset keeps the dividend positive; it is a multiple of 5 * 2^32
  localparam logic [XW-1:0] OFS  = XW'(5) << DV_IN_W;
  localparam logic [XW-1:0] FIVE = XW'(5);

  localparam logic [2:0] DS_IDLE = 3'd0, DS_SEED = 3'd1, DS_F4 = 3'd2, DS_F8 = 3'd3,
                         DS_F16 = 3'd4, DS_F32 = 3'd5, DS_REM = 3'd6, DS_FIX = 3'd7;

  logic [2:0]    step_r;
  logic [XW-1:0] x_r, q_r, r_r;
  logic [XW-1:0] q_sh;

  assign q_sh = q_r >> 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= DS_IDLE;
    end else begin
      case (step_r)
        DS_IDLE: begin
          if (start) begin
            x_r    <= XW'(t) + OFS;
            step_r <= DS_SEED;
          end
        end
        // q approaches 0.8 * x from below: 0.75 * (1 + 1/16)(1 + 1/256)...
        DS_SEED: begin
          q_r    <= (x_r >> 1) + (x_r >> 2);
          step_r <= DS_F4;
        end
        DS_F4: begin
          q_r    <= q_r + (q_r >> 4);
          step_r <= DS_F8;
        end
        DS_F8: begin
          q_r    <= q_r + (q_r >> 8);
          step_r <= DS_F16;
        end
        DS_F16: begin
          q_r    <= q_r + (q_r >> 16);
          step_r <= DS_F32;
        end
        DS_F32: begin
          q_r    <= q_r + (q_r >> 32);
          step_r <= DS_REM;
        end
        // estimate never exceeds the quotient and falls short by at most three
        DS_REM: begin
          q_r    <= q_sh;
          r_r    <= x_r - (q_sh << 2) - q_sh;
          step_r <= DS_FIX;
        end
        DS_FIX: begin
          if (r_r >= FIVE) begin
            q_r <= q_r + XW'(1);
            r_r <= r_r - FIVE;
          end else begin
            step_r <= DS_IDLE;
          end
        end
        default: step_r <= DS_IDLE;
      endcase
    end
  end

  assign busy = (step_r != DS_IDLE);
  assign q    = q_r[31:0];
endmodule
`default_nettype wire

### sv/motor_position_speed_controller.sv
// Top level: config registers, loop state and sequencer over one multiplier.
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | reference, encoder_count, restart
//  out_ch   | out | valid/ready   | voltage, saturated
//  cfg_*    | in  | cfg_we        | cfg_index, cfg_data
// Each accepted beat runs four tap passes, then the two integrator updates
// (skipped at zero gain or after a clamped output); the speed filter's divide-by-5
// runs beside the taps, and the sequencer waits for it if the taps finish first.
// Busy from acceptance until the result is loaded into the output register;
// a result held by out_ch stalls only the last step. Synchronous reset
// clears all loop state and config to reset values.
`default_nettype none
module motor_position_speed_controller #(
  parameter int TAP_COUNT     = mpsc_pkg::TAP_COUNT_DEF,
  parameter int VOLTAGE_LIMIT = mpsc_pkg::VOLT_LIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mpsc_in_if.sink     in_ch,
  mpsc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import mpsc_pkg::*;

  localparam int KW = $clog2(TAP_COUNT + 1);
  localparam int IW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  localparam logic [2:0] REG_SETUP = 3'd0, REG_FBC = 3'd1, REG_FFC = 3'd2,
                         REG_DNC = 3'd3, REG_GAIN = 3'd4, REG_RATE = 3'd5,
                         REG_APC = 3'd6, REG_MLT = 3'd7;

  localparam logic [3:0] ST_IDLE = 4'd0, ST_ANG = 4'd1, ST_ANGW = 4'd2,
                         ST_SPD = 4'd3, ST_SPDW = 4'd4, ST_MAC = 4'd5,
                         ST_MACW = 4'd6, ST_INT = 4'd7, ST_INTW = 4'd8,
                         ST_EMF = 4'd9, ST_EMFW = 4'd10, ST_FIN = 4'd11;

  localparam prod_t MAX32 = PROD_W'(64'sd2147483647);
  localparam prod_t MIN32 = -PROD_W'(64'sd2147483648);
  localparam prod_t MAX48 = PROD_W'(64'sd140737488355327);
  localparam prod_t MIN48 = -PROD_W'(64'sd140737488355328);
  localparam prod_t VMAX  = PROD_W'(VOLTAGE_LIMIT) <<< 16;

  function automatic sig_t sat32(input prod_t x);
    prod_t y;
    y = (x > MAX32) ? MAX32 : ((x < MIN32) ? MIN32 : x);
    return y[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input prod_t x);
    prod_t y;
    y = (x > MAX48) ? MAX48 : ((x < MIN48) ? MIN48 : x);
    return y[47:0];
  endfunction

  function automatic prod_t rnd16(input prod_t x);
    return (x + (PROD_W'(1) <<< 15)) >>> 16;
  endfunction

  function automatic logic signed [15:0] coef_at(input logic [63:0] pk,
                                                 input logic [3:0] k);
    return (k < 4'd4) ? pk[16*k[1:0] +: 16] : 16'sd0;
  endfunction

  function automatic logic [KW-1:0] taps(input logic [2:0] f);
    return (4'(f) > 4'(TAP_COUNT)) ? KW'(TAP_COUNT) : KW'(f);
  endfunction

  // configuration
  logic [9:0]  setup_r;
  logic [63:0] fbc_r, ffc_r, dnc_r, mlt_r;
  logic [30:0] gain_r;
  logic [15:0] rate_r;
  logic [31:0] apc_r;

  // loop state
  sig_t mh_r [TAP_COUNT];
  sig_t rh_r [TAP_COUNT];
  sig_t ffh_r [TAP_COUNT];
  sig_t fbh_r [TAP_COUNT];
  logic signed [47:0] iref_r, imeas_r;
  sig_t prev_r, filt_r;
  logic sat_flag_r;

  // working registers
  logic [3:0]  state_r;
  sig_t        ref_r, cnt_r, ang_r, ufb_r, uff_r;
  logic        rst_flag_r, isel_r;
  prod_t       acc_fb_r, acc_ff_r, emf_r, unsat_r, uv_r;
  logic [1:0]  phase_r;
  logic [KW-1:0] k_r;
  logic        out_valid_r, sat_out_r;
  sig_t        dv_r;

  // shared units
  mop_t  mul_a, mul_b;
  prod_t prod;
  logic  div_start, div_busy;
  sig_t  div_q;
  logic signed [DV_IN_W-1:0] div_t;

  mpsc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  mpsc_div5 u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .t(div_t),
                   .busy(div_busy), .q(div_q));

  logic [KW-1:0] nd, nc, nf, n_cur;
  logic [IW-1:0] idx;
  logic signed [15:0] cur_coef;
  sig_t cur_data, raw_spd, meas;
  logic speed_mode;

  assign speed_mode = setup_r[0];
  assign nd = taps(setup_r[3:1]);
  assign nc = taps(setup_r[6:4]);
  assign nf = taps(setup_r[9:7]);
  assign raw_spd = sat32(prod);
  assign meas = speed_mode ? raw_spd : ang_r;

  always_comb begin
    case (phase_r)
      2'd0: begin n_cur = nd; cur_coef = coef_at(fbc_r, 4'(k_r)); end
      2'd1: begin n_cur = nc; cur_coef = coef_at(ffc_r, 4'(k_r)); end
      default: begin n_cur = nf; cur_coef = coef_at(dnc_r, 4'(k_r)); end
    endcase
    idx = IW'(KW'(n_cur - KW'(1) - k_r));
    case (phase_r)
      2'd0: cur_data = mh_r[idx];
      2'd1: cur_data = rh_r[idx];
      2'd2: cur_data = fbh_r[idx];
      default: cur_data = ffh_r[idx];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_ANG: begin mul_a = MUL_W'(cnt_r); mul_b = {1'b0, apc_r}; end
      ST_SPD: begin
        mul_a = MUL_W'(ang_r) - MUL_W'(prev_r);
        mul_b = {17'b0, rate_r};
      end
      ST_MAC: begin mul_a = MUL_W'(cur_coef); mul_b = MUL_W'(cur_data); end
      ST_INT: begin
        mul_a = {2'b0, gain_r};
        mul_b = isel_r ? MUL_W'(mh_r[0]) : MUL_W'(ref_r);
      end
      ST_EMF: begin mul_a = {1'b0, mlt_r[63:32]}; mul_b = MUL_W'(div_q); end
      default: ;
    endcase
  end

  assign div_start = (state_r == ST_SPDW);
  assign div_t = DV_IN_W'(raw_spd) + (DV_IN_W'(filt_r) <<< 2) + DV_IN_W'(2);

  // final window clamp
  prod_t upper, lower, u_win;
  sig_t  u32;
  always_comb begin
    upper = emf_r + PROD_W'({1'b0, mlt_r[31:0]});
    lower = emf_r - PROD_W'({1'b0, mlt_r[31:0]});
    u_win = (uv_r > upper) ? upper : ((uv_r < lower) ? lower : uv_r);
    u32   = sat32(u_win);
  end

  logic fin_go;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r <= '0; fbc_r <= '0; ffc_r <= '0; dnc_r <= '0;
      gain_r <= '0; rate_r <= 16'd1000; apc_r <= '0; mlt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP: setup_r <= cfg_data[9:0];
        REG_FBC:   fbc_r   <= cfg_data;
        REG_FFC:   ffc_r   <= cfg_data;
        REG_DNC:   dnc_r   <= cfg_data;
        REG_GAIN:  gain_r  <= cfg_data[30:0];
        REG_RATE:  rate_r  <= cfg_data[15:0];
        REG_APC:   apc_r   <= cfg_data[31:0];
        REG_MLT:   mlt_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        mh_r[i] <= '0; rh_r[i] <= '0; ffh_r[i] <= '0; fbh_r[i] <= '0;
      end
      iref_r <= '0; imeas_r <= '0; prev_r <= '0; filt_r <= '0;
      sat_flag_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ref_r <= in_ch.reference;
            cnt_r <= in_ch.encoder_count;
            rst_flag_r <= in_ch.restart;
            state_r <= ST_ANG;
          end
        end
        ST_ANG: state_r <= ST_ANGW;
        ST_ANGW: begin
          ang_r <= sat32(rnd16(prod));
          if (rst_flag_r) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
              mh_r[i]  <= speed_mode ? '0 : sat32(rnd16(prod));
              rh_r[i]  <= ref_r;
              ffh_r[i] <= '0;
              fbh_r[i] <= '0;
            end
            sat_flag_r <= 1'b0;
            prev_r <= sat32(rnd16(prod));
            iref_r <= '0; imeas_r <= '0; filt_r <= '0;
          end
          state_r <= ST_SPD;
        end
        ST_SPD: state_r <= ST_SPDW;
        ST_SPDW: begin
          mh_r[0] <= meas;
          rh_r[0] <= ref_r;
          acc_fb_r <= '0; acc_ff_r <= '0;
          phase_r <= 2'd0; k_r <= '0;
          state_r <= ST_MAC;
        end
        ST_MAC: begin
          if (k_r >= n_cur) begin
            k_r <= '0;
            if (phase_r == 2'd3) begin
              ufb_r <= sat32((acc_fb_r + (PROD_W'(1) <<< 11)) >>> 12);
              uff_r <= sat32((acc_ff_r + (PROD_W'(1) <<< 11)) >>> 12);
              isel_r <= 1'b0;
              state_r <= (gain_r != '0 && !sat_flag_r) ? ST_INT : ST_EMF;
            end else begin
              phase_r <= phase_r + 2'd1;
            end
          end else begin
            state_r <= ST_MACW;
          end
        end
        ST_MACW: begin
          case (phase_r)
            2'd0: acc_fb_r <= acc_fb_r + prod;
            2'd1: acc_ff_r <= acc_ff_r + prod;
            2'd2: acc_fb_r <= acc_fb_r - prod;
            default: acc_ff_r <= acc_ff_r - prod;
          endcase
          k_r <= k_r + KW'(1);
          state_r <= ST_MAC;
        end
        ST_INT: state_r <= ST_INTW;
        ST_INTW: begin
          if (!isel_r) begin
            iref_r <= sat48(PROD_W'(iref_r) + rnd16(prod));
            isel_r <= 1'b1;
            state_r <= ST_INT;
          end else begin
            imeas_r <= sat48(PROD_W'(imeas_r) + rnd16(prod));
            state_r <= ST_EMF;
          end
        end
        ST_EMF: begin
          if (!div_busy) begin
            filt_r <= div_q;
            state_r <= ST_EMFW;
          end
        end
        ST_EMFW: begin
          emf_r <= rnd16(prod);
          unsat_r <= (PROD_W'(uff_r) + PROD_W'(iref_r))
                   - (PROD_W'(ufb_r) + PROD_W'(imeas_r));
          begin
            prod_t us;
            us = (PROD_W'(uff_r) + PROD_W'(iref_r)) - (PROD_W'(ufb_r) + PROD_W'(imeas_r));
            uv_r <= (us > VMAX) ? VMAX : ((us < -VMAX) ? -VMAX : us);
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            sat_flag_r <= (PROD_W'(u32) != unsat_r);
            sat_out_r <= (PROD_W'(u32) != unsat_r);
            dv_r <= u32;
            for (int i = 1; i < TAP_COUNT; i++) begin
              if (i < int'(nd)) mh_r[i] <= mh_r[i-1];
              if (i < int'(nc)) rh_r[i] <= rh_r[i-1];
              if (i < int'(nf)) begin
                fbh_r[i] <= fbh_r[i-1];
                ffh_r[i] <= ffh_r[i-1];
              end
            end
            fbh_r[0] <= ufb_r;
            ffh_r[0] <= uff_r;
            prev_r <= ang_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.voltage  = dv_r;
  assign out_ch.saturated = sat_out_r;
endmodule
`default_nettype wire

### sim/tb_regs_pkg.sv
// Configuration register indexes shared by the testbench files.
package tb_regs_pkg;
  typedef enum logic [2:0] {
    REG_LOOP_SETUP      = 3'd0,
    REG_FB_COEFFS       = 3'd1,
    REG_FF_COEFFS       = 3'd2,
    REG_DEN_COEFFS      = 3'd3,
    REG_INT_GAIN        = 3'd4,
    REG_SAMPLE_RATE     = 3'd5,
    REG_ANGLE_PER_COUNT = 3'd6,
    REG_MOTOR_LIMITS    = 3'd7
  } reg_idx_e;
endpackage

### sim/mpsc_checker.sv
// Controller scoreboard: watches config and channels, predicts drive beats, compares.
module mpsc_checker
  import mpsc_pkg::*;
  import tb_regs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mpsc_in_if          in_mon,
  mpsc_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sig_t drive;
    logic sat;
  } drive_beat_t;

  localparam int NTAP = TAP_COUNT_DEF;
  localparam longint VLIM = longint'(VOLT_LIM_DEF) <<< 16;

  logic [9:0]  setup;
  logic [63:0] fb_c, ff_c, den_c, lim_terms;
  logic [30:0] gain;
  logic [15:0] rate;
  logic [31:0] apc;

  sig_t   meas_h[NTAP], ref_h[NTAP], ffo_h[NTAP], fbo_h[NTAP];
  longint ref_int, meas_int;
  sig_t   prev_ang, filt_spd;
  logic   sat_flag;

  drive_beat_t expected_drive[$];

  function automatic longint rnd_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat_to(longint x, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint coef(logic [63:0] p, int tap);
    if (tap >= 4) return 0;
    return longint'($signed(p[16*tap +: 16]));
  endfunction

  function automatic int tap_n(int sh);
    int n;
    n = int'(setup[sh +: 3]);
    return (n > NTAP) ? NTAP : n;
  endfunction

  function automatic longint div5(longint s);
    longint t;
    t = s + 2;
    if (t >= 0) return t / 5;
    return -(((-(t + 1)) / 5) + 1);
  endfunction

  function automatic void predict_drive(sig_t r, sig_t c, logic rs);
    logic   spd_mode;
    int     nd, nc, nf;
    longint ang, raw, meas, acc_fb, acc_ff, ufb, uff, unsat, u, f, kn, rim, emf;
    drive_beat_t e;
    spd_mode = setup[0];
    nd = tap_n(1);
    nc = tap_n(4);
    nf = tap_n(7);
    ang = sat_to(rnd_shift(longint'(c) * longint'({32'b0, apc}), 16), 32);
    if (rs) begin
      for (int i = 0; i < NTAP; i++) begin
        meas_h[i] = spd_mode ? '0 : sig_t'(ang);
        ref_h[i]  = r;
        ffo_h[i]  = '0;
        fbo_h[i]  = '0;
      end
      sat_flag = 1'b0;
      prev_ang = sig_t'(ang);
      ref_int  = 0;
      meas_int = 0;
      filt_spd = '0;
    end
    raw = sat_to((ang - longint'(prev_ang)) * longint'({48'b0, rate}), 32);
    meas = spd_mode ? raw : ang;
    meas_h[0] = sig_t'(meas);
    ref_h[0]  = r;
    acc_fb = 0;
    acc_ff = 0;
    for (int i = 0; i < nd; i++) acc_fb += coef(fb_c, i) * longint'(meas_h[nd-1-i]);
    for (int i = 0; i < nc; i++) acc_ff += coef(ff_c, i) * longint'(ref_h[nc-1-i]);
    for (int i = 0; i < nf; i++) begin
      f = coef(den_c, i);
      acc_fb -= f * longint'(fbo_h[nf-1-i]);
      acc_ff -= f * longint'(ffo_h[nf-1-i]);
    end
    ufb = sat_to(rnd_shift(acc_fb, 12), 32);
    uff = sat_to(rnd_shift(acc_ff, 12), 32);
    // integrators hold while the last output was clamped
    if (gain != 0 && !sat_flag) begin
      ref_int  = sat_to(ref_int + rnd_shift(longint'(gain) * longint'(r), 16), 48);
      meas_int = sat_to(meas_int + rnd_shift(longint'(gain) * meas, 16), 48);
    end
    unsat = (uff + ref_int) - (ufb + meas_int);
    u = unsat;
    if (u > VLIM) u = VLIM;
    else if (u < -VLIM) u = -VLIM;
    filt_spd = sig_t'(div5(raw + 4 * longint'(filt_spd)));
    kn  = longint'({32'b0, lim_terms[63:32]});
    rim = longint'({32'b0, lim_terms[31:0]});
    emf = rnd_shift(kn * longint'(filt_spd), 16);
    if (u > emf + rim) u = emf + rim;
    else if (u < emf - rim) u = emf - rim;
    u = sat_to(u, 32);
    sat_flag = (u != unsat);
    for (int i = nd; i > 1; i--) meas_h[i-1] = meas_h[i-2];
    for (int i = nc; i > 1; i--) ref_h[i-1] = ref_h[i-2];
    for (int i = nf; i > 1; i--) begin
      fbo_h[i-1] = fbo_h[i-2];
      ffo_h[i-1] = ffo_h[i-2];
    end
    fbo_h[0] = sig_t'(ufb);
    ffo_h[0] = sig_t'(uff);
    prev_ang = sig_t'(ang);
    e.drive = sig_t'(u);
    e.sat   = sat_flag;
    expected_drive.push_back(e);
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    drive_beat_t e;
    if (!rst_n) begin
      setup = '0; fb_c = '0; ff_c = '0; den_c = '0; gain = '0;
      rate = 16'd1000; apc = '0; lim_terms = '0;
      for (int i = 0; i < NTAP; i++) begin
        meas_h[i] = '0; ref_h[i] = '0; ffo_h[i] = '0; fbo_h[i] = '0;
      end
      ref_int = 0; meas_int = 0; prev_ang = '0; filt_spd = '0; sat_flag = 1'b0;
      expected_drive.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_e'(cfg_index))
          REG_LOOP_SETUP:      setup = cfg_data[9:0];
          REG_FB_COEFFS:       fb_c = cfg_data;
          REG_FF_COEFFS:       ff_c = cfg_data;
          REG_DEN_COEFFS:      den_c = cfg_data;
          REG_INT_GAIN:        gain = cfg_data[30:0];
          REG_SAMPLE_RATE:     rate = cfg_data[15:0];
          REG_ANGLE_PER_COUNT: apc = cfg_data[31:0];
          REG_MOTOR_LIMITS:    lim_terms = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_drive(in_mon.reference, in_mon.encoder_count, in_mon.restart);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_drive.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result beat v=%0d s=%0b", $realtime,
                     out_mon.voltage, out_mon.saturated);
        end else begin
          e = expected_drive.pop_front();
          if (out_mon.voltage !== e.drive || out_mon.saturated !== e.sat) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp v=%0d s=%0b got v=%0d s=%0b", $realtime,
                       e.drive, e.sat, out_mon.voltage, out_mon.saturated);
          end
        end
      end
    end
    pending = expected_drive.size();
  end
endmodule

### sim/tb_top.sv
// Testbench top: clock, reset, config phases, stimulus, stall control and verdict.
module tb_top;
  import mpsc_pkg::*;
  import tb_regs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          errors, pending;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          quiet_cycles = 0;
  logic signed [31:0] enc_pos = 0;

  mpsc_in_if  in_ch ();
  mpsc_out_if out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.reference = '0;
    in_ch.encoder_count = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
  end

  always #4 clk = ~clk;

  motor_position_speed_controller u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mpsc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= !(rst_n && idle_on && $urandom_range(99) < 15) && rst_n;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(logic [9:0] setup, logic [63:0] fb, logic [63:0] ff,
                            logic [63:0] den, logic [30:0] g, logic [15:0] rate,
                            logic [31:0] apc, logic [63:0] lim);
    write_reg(REG_LOOP_SETUP, {54'b0, setup});
    write_reg(REG_FB_COEFFS, fb);
    write_reg(REG_FF_COEFFS, ff);
    write_reg(REG_DEN_COEFFS, den);
    write_reg(REG_INT_GAIN, {33'b0, g});
    write_reg(REG_SAMPLE_RATE, {48'b0, rate});
    write_reg(REG_ANGLE_PER_COUNT, {32'b0, apc});
    write_reg(REG_MOTOR_LIMITS, lim);
  endtask

  // sender is left at a falling edge with the beat accepted
  task automatic send_tick(sig_t r, sig_t c, logic rs);
    if (idle_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.reference <= r;
    in_ch.encoder_count <= c;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] small_coeffs(int span);
    logic [63:0] p;
    for (int i = 0; i < 4; i++)
      p[16*i +: 16] = 16'($signed($urandom_range(2 * span)) - span);
    return p;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly a smooth trajectory with modest targets, some full-range noise
  task automatic random_ticks(int n);
    sig_t r, c;
    logic rs;
    for (int k = 0; k < n; k++) begin
      rs = (k == 0) || ($urandom_range(99) < 3);
      if ($urandom_range(99) < 10) begin
        r = $urandom;
        c = $urandom;
        enc_pos = c;
      end else begin
        r = sig_t'($signed($urandom_range(1 << 19)) - (1 << 18));
        enc_pos = enc_pos + ($signed($urandom_range(400)) - 200);
        c = enc_pos;
      end
      send_tick(r, c, rs);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: position mode, 2/2/1 taps, moderate gains
    load_setup({3'd1, 3'd2, 3'd2, 1'b0}, 64'h0000_0000_F800_1000,
               64'h0000_0000_0800_1000, 64'h0000_0000_0000_0800, 31'h0000_4000,
               16'd1000, 32'h0010_0000, {32'h0000_8000, 32'h000C_0000});
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_tick(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_tick('0, '0, 1'b0);
    send_tick(32'sh0001_0000, 32'sd100, 1'b0);
    send_tick(32'sh0001_0000, 32'sd100, 1'b1);
    send_tick(-32'sh0001_0000, -32'sd50, 1'b0);
    send_tick(32'sh000A_0000, 32'sd0, 1'b0);
    drain();
    // speed mode, taps above the limit, extreme coefficients and scales
    load_setup(10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_8000_7FFF_8000,
               64'h8000_7FFF_8000_7FFF, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_tick(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_tick(32'sh0000_0001, 32'sd1, 1'b0);
    send_tick('0, -32'sd1, 1'b0);
    send_tick(32'sh7FFF_FFFF, '0, 1'b0);
    drain();
    // zero taps, zero gain, zero rate and window
    load_setup(10'h001, '0, '0, '0, '0, 16'd0, 32'd0, '0);
    send_tick(32'sh0003_0000, 32'sd7, 1'b1);
    send_tick(32'sh8000_0000, 32'sd9, 1'b0);
    send_tick(32'sh7FFF_FFFF, -32'sd9, 1'b0);
    drain();
    write_reg(REG_SAMPLE_RATE, 64'd1);
    send_tick(32'sh0001_0000, 32'sd5, 1'b1);
    send_tick(32'sh0001_0000, 32'sd50, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph != 3);
      if (ph == 6)
        load_setup(10'($urandom), rand64(), rand64(), rand64(), 31'($urandom),
                   16'($urandom_range(1, 65535)), $urandom, rand64());
      else
        load_setup({3'($urandom_range(4)), 3'($urandom_range(4)), 3'($urandom_range(4)),
                    1'(ph[0])},
                   small_coeffs(8192), small_coeffs(8192), small_coeffs(1500),
                   31'($urandom_range(1 << 14)), 16'($urandom_range(100, 20000)),
                   $urandom_range(1 << 14, 1 << 22),
                   {32'($urandom_range(1 << 10, 1 << 17)), 32'($urandom_range(1 << 18, 1 << 21))});
      if (ph == 4) hold_req = 1'b1;
      random_ticks(170);
      drain();
    end
    idle_on = 1'b1;

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
